[sv/sha256_message_hasher_defines.svh]
// Assertion macros for the SHA-256 message hasher.
// No dependencies; included by modules that carry assertions.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMP(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
`define SHA_ASSERT_NXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`else
`define SHA_ASSERT_IMP(label, clk, rstn, a, c, msg)
`define SHA_ASSERT_NXT(label, clk, rstn, a, c, msg)
`endif
`endif

[sv/sha_pkg.sv]
// Types, constants and round functions for the SHA-256 message hasher.
// No dependencies.
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       count_len;
        logic       set_len;
        logic       start_blk;
        logic       round;
        logic       finish_blk;
        logic       reset_all;
        logic [2:0] out_sel;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round_idx;
    } sha_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction
endpackage

[sv/sha256_message_hasher.sv]
// SHA-256 message hasher top level: joins the controller and the datapath.
// Depends on sha_pkg, sha_controller and sha_datapath.
// One byte is taken per cycle while a block fills; the 64th byte of a block starts
// the rounds on the single shared round unit and then the chaining add, and no byte
// is taken until the block is done. An end-of-message word adds padding (loaded
// byte by byte, with one or two extra compressions) and then the digest leaves as
// eight words, word 0 first, with the last marked.
module sha256_message_hasher import sha_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);
    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] hash_word;

    sha_controller u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .stat, .hash_word, .cmd
    );

    sha_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .hash_word
    );
endmodule

[sv/sha_datapath.sv]
// SHA-256 datapath: byte packing, schedule window, round logic, chaining hash.
// Depends on sha_pkg and the assertion macro header.
`include "sha256_message_hasher_defines.svh"
module sha_datapath import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    output logic [31:0] hash_word
);
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  t_reg;

    logic [31:0] x, y, wnew, wt, t1, t2, e, a;
    logic [3:0]  ti;
    logic [1:0]  bp;

    always_comb begin
        ti = t_reg[3:0];
        x = w_reg[ti + 4'd1];
        y = w_reg[ti + 4'd14];
        wnew = w_reg[ti] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w_reg[ti + 4'd9]
             + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        wt = (t_reg < 6'd16) ? w_reg[ti] : wnew;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[t_reg] + wt;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        bp = fill_reg[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_all) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            fill_reg <= '0;
            len_reg  <= '0;
            t_reg    <= '0;
        end else begin
            if (cmd.load_byte) begin
                if (bp == 2'd0)
                    w_reg[fill_reg[5:2]] <= {cmd.byte_val, 24'd0};
                else
                    w_reg[fill_reg[5:2]] <= w_reg[fill_reg[5:2]]
                        | ({24'd0, cmd.byte_val} << (5'd24 - {bp, 3'd0}));
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.count_len) len_reg <= len_reg + 64'd8;
            if (cmd.set_len) begin
                w_reg[14] <= len_reg[63:32];
                w_reg[15] <= len_reg[31:0];
            end
            if (cmd.start_blk) begin
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                t_reg <= '0;
            end
            if (cmd.round) begin
                if (t_reg >= 6'd16) w_reg[ti] <= wnew;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                t_reg <= t_reg + 6'd1;
            end
            if (cmd.finish_blk) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            end
        end
    end

    assign stat.fill = fill_reg;
    assign stat.round_idx = t_reg;
    assign hash_word = h_reg[cmd.out_sel];

    `SHA_ASSERT_NXT(a_fill_wrap, aclk, aresetn, cmd.load_byte && fill_reg == 6'd63 && !cmd.reset_all, fill_reg == 6'd0, "fill wrap")
    `SHA_ASSERT_IMP(a_round_excl, aclk, aresetn, cmd.round, !cmd.load_byte && !cmd.finish_blk, "round overlap")
    `SHA_ASSERT_NXT(a_len_step, aclk, aresetn, cmd.count_len && !cmd.reset_all, len_reg == $past(len_reg) + 64'd8, "len step")
endmodule

[sv/sha_controller.sv]
// SHA-256 controller: sequences byte loads, padding, rounds and digest output.
// Depends on sha_pkg and the assertion macro header.
`include "sha256_message_hasher_defines.svh"
module sha_controller import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sha_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output sha_out_t    m_data,
    input  sha_stat_t   stat,
    input  logic [31:0] hash_word,
    output sha_cmd_t    cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_ZERO = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       final_reg, final_next;   // block in flight is the padded last one
    logic       eom_reg, eom_next;       // end seen, padding pending
    logic       padding_reg, padding_next;
    logic [2:0] idx_reg, idx_next;
    logic       full;

    always_comb begin
        cmd = '0;
        cmd.out_sel = idx_reg;
        state_next = state_reg;
        final_next = final_reg;
        eom_next = eom_reg;
        idx_next = idx_reg;
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
        m_data.digest_word = hash_word;
        m_data.word_index = idx_reg;
        m_data.last_word = (idx_reg == 3'd7);
        full = (stat.fill == 6'd63);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_byte = s_data.byte_present;
                    cmd.byte_val = s_data.data_byte;
                    cmd.count_len = s_data.byte_present;
                    eom_next = s_data.end_of_message;
                    if (s_data.byte_present && full) begin
                        cmd.start_blk = 1'b1;
                        state_next = ST_RND;
                    end else if (s_data.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.load_byte = 1'b1;
                cmd.byte_val = 8'h80;
                eom_next = 1'b0;
                if (full) begin
                    cmd.start_blk = 1'b1;
                    state_next = ST_RND;
                end else if (stat.fill == 6'd55) begin
                    cmd.set_len = 1'b1;
                    cmd.start_blk = 1'b1;
                    final_next = 1'b1;
                    state_next = ST_RND;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (stat.fill == 6'd56) begin
                    cmd.set_len = 1'b1;
                    cmd.start_blk = 1'b1;
                    final_next = 1'b1;
                    state_next = ST_RND;
                end else begin
                    cmd.load_byte = 1'b1;
                    cmd.byte_val = 8'h00;
                    if (full) begin
                        cmd.start_blk = 1'b1;
                        state_next = ST_RND;
                    end
                end
            end
            ST_RND: begin
                cmd.round = 1'b1;
                if (stat.round_idx == 6'd63) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish_blk = 1'b1;
                if (final_reg) begin
                    idx_next = 3'd0;
                    state_next = ST_OUT;
                end else if (eom_reg) begin
                    state_next = ST_PAD;
                end else if (padding_reg) begin
                    // padding-only second block
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reset_all = 1'b1;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        padding_next = padding_reg;
        if (state_reg == ST_PAD) padding_next = 1'b1;
        if (state_reg == ST_OUT || state_reg == ST_IDLE) padding_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            eom_reg <= 1'b0;
            idx_reg <= '0;
            padding_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
            eom_reg <= eom_next;
            idx_reg <= idx_next;
            padding_reg <= padding_next;
        end
    end

    `SHA_ASSERT_IMP(a_excl, aclk, aresetn, s_ready, !m_valid, "ready and valid together")
    `SHA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && idx_reg == $past(idx_reg), "output slipped")
    `SHA_ASSERT_NXT(a_rnd_to_fin, aclk, aresetn, state_reg == ST_RND && stat.round_idx == 6'd63, state_reg == ST_FIN, "rounds overrun")
endmodule
